// ----- src/request_header_tokenizer_macros.svh -----
// Assertion macros used by the tokenizer top level.
`ifndef REQUEST_HEADER_TOKENIZER_MACROS_SVH
`define REQUEST_HEADER_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RHT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rht check failed");

// Next-cycle implication, disabled during reset.
`define RHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rht check failed");

`endif

// ----- src/rht_pkg.sv -----
// ----------------------------------------------------------------------------
// rht_pkg
// Types, codes and limits shared by the request header tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rht_pkg;

  localparam int VALUE_CAP = 1024;
  localparam int NAME_CAP  = 128;
  localparam int LEN_W     = 11;
  localparam int NAME_W    = 8;

  localparam logic [LEN_W-1:0]  VALUE_CAP_L = LEN_W'(VALUE_CAP);
  localparam logic [NAME_W-1:0] NAME_CAP_L  = NAME_W'(NAME_CAP);

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SP    = 8'h20;

  typedef enum logic [2:0] {
    EV_METHOD_BYTE = 3'd0,
    EV_METHOD_END  = 3'd1,
    EV_NAME_BYTE   = 3'd2,
    EV_VALUE_BYTE  = 3'd3,
    EV_FIELD_END   = 3'd4,
    EV_HEADERS_END = 3'd5
  } event_kind_t;

  typedef enum logic [9:0] {
    ST_START      = 10'b00_0000_0001,
    ST_METHOD     = 10'b00_0000_0010,
    ST_METHOD_GAP = 10'b00_0000_0100,
    ST_URL        = 10'b00_0000_1000,
    ST_URL_GAP    = 10'b00_0001_0000,
    ST_SKIP       = 10'b00_0010_0000,
    ST_LINE       = 10'b00_0100_0000,
    ST_NAME       = 10'b00_1000_0000,
    ST_NAME_GAP   = 10'b01_0000_0000,
    ST_VALUE      = 10'b10_0000_0000
  } parse_state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } stage_t;

  typedef struct packed {
    event_kind_t       kind;
    logic [7:0]        token_byte;
    logic [LEN_W-1:0]  token_length;
    logic [NAME_W-1:0] name_count;
  } token_t;

  function automatic logic is_ws(logic [7:0] b);
    return (b == CHAR_SP) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
  endfunction

endpackage

// ----- src/rht_channels.sv -----
// ----------------------------------------------------------------------------
// rht_channels
// Valid/ready channels for the byte stream and the token stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rht_byte_if;
  import rht_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface rht_token_if;
  import rht_pkg::*;
  logic              valid;
  logic              ready;
  event_kind_t       event_kind;
  logic [7:0]        token_byte;
  logic [LEN_W-1:0]  token_length;
  logic [NAME_W-1:0] name_count;

  modport source (output valid, output event_kind, output token_byte,
                  output token_length, output name_count, input ready);
  modport sink (input valid, input event_kind, input token_byte,
                input token_length, input name_count, output ready);
endinterface

// ----- src/rht_input_reg.sv -----
// ----------------------------------------------------------------------------
// rht_input_reg
// Input register for the byte stream; holds one beat until the parser
// consumes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rht_input_reg (
  input  logic           clk,
  input  logic           rst,
  rht_byte_if.sink       bytes,
  input  logic           advance,
  output rht_pkg::stage_t stage
);
  import rht_pkg::*;

  assign bytes.ready = !stage.valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (bytes.ready) begin
      stage.valid <= bytes.valid;
    end
    if (bytes.valid && bytes.ready) begin
      stage.data <= bytes.data_byte;
    end
  end

endmodule

// ----- src/rht_parser.sv -----
// ----------------------------------------------------------------------------
// rht_parser
// Parse state and length counters; turns one byte into at most one token.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rht_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [7:0]          data_byte,
  output logic                ev_valid,
  output rht_pkg::token_t     ev
);
  import rht_pkg::*;

  parse_state_t      state, state_next;
  logic [NAME_W-1:0] name_len, name_len_next;
  logic [LEN_W-1:0]  value_len, value_len_next;
  logic [LEN_W-1:0]  trimmed_len, trimmed_len_next;

  logic              ws, is_lf;
  logic              do_method, do_name, do_value;
  logic              clear_all, clear_value;
  logic [NAME_W-1:0] nlen_base;
  logic [LEN_W-1:0]  vlen_base, tlen_base, vlen_inc;

  assign ws    = is_ws(data_byte);
  assign is_lf = (data_byte == CHAR_LF);

  always_comb begin
    state_next  = state;
    do_method   = 1'b0;
    do_name     = 1'b0;
    do_value    = 1'b0;
    clear_all   = 1'b0;
    clear_value = 1'b0;
    ev_valid    = 1'b0;
    ev          = '0;

    case (state)
      ST_START: begin
        if (!ws) begin
          clear_all  = 1'b1;
          state_next = ST_METHOD;
          do_method  = 1'b1;
        end
      end
      ST_METHOD: begin
        do_method = 1'b1;
      end
      ST_METHOD_GAP: begin
        if (is_lf) state_next = ST_LINE;
        else if (!ws) state_next = ST_URL;
      end
      ST_URL: begin
        if (is_lf) state_next = ST_LINE;
        else if (ws) state_next = ST_URL_GAP;
      end
      ST_URL_GAP: begin
        if (is_lf) state_next = ST_LINE;
        else if (!ws) state_next = ST_SKIP;
      end
      ST_SKIP: begin
        if (is_lf) state_next = ST_LINE;
      end
      ST_LINE: begin
        if (data_byte == CHAR_CR) begin
          state_next = ST_LINE;
        end else if (is_lf) begin
          state_next = ST_START;
          ev_valid   = 1'b1;
          ev.kind    = EV_HEADERS_END;
        end else begin
          clear_all  = 1'b1;
          state_next = ST_NAME;
          do_name    = 1'b1;
        end
      end
      ST_NAME: begin
        do_name = 1'b1;
      end
      ST_NAME_GAP: begin
        if (is_lf || !ws) begin
          clear_value = 1'b1;
          state_next  = ST_VALUE;
          do_value    = 1'b1;
        end
      end
      ST_VALUE: begin
        do_value = 1'b1;
      end
      default: begin
        state_next = ST_START;
      end
    endcase

    nlen_base = clear_all ? '0 : name_len;
    vlen_base = (clear_all || clear_value) ? '0 : value_len;
    tlen_base = (clear_all || clear_value) ? '0 : trimmed_len;
    vlen_inc  = vlen_base + LEN_W'(1);

    name_len_next    = nlen_base;
    value_len_next   = vlen_base;
    trimmed_len_next = tlen_base;

    if (do_method) begin
      if (ws) begin
        value_len_next  = '0;
        state_next      = is_lf ? ST_LINE : ST_METHOD_GAP;
        ev_valid        = 1'b1;
        ev.kind         = EV_METHOD_END;
        ev.token_length = vlen_base;
      end else if (vlen_base < VALUE_CAP_L) begin
        value_len_next = vlen_inc;
        ev_valid       = 1'b1;
        ev.kind        = EV_METHOD_BYTE;
        ev.token_byte  = data_byte;
      end
    end

    if (do_name) begin
      if (data_byte == CHAR_COLON) begin
        state_next = ST_NAME_GAP;
      end else if (is_lf) begin
        state_next = ST_LINE;
      end else if (nlen_base < NAME_CAP_L) begin
        name_len_next = nlen_base + NAME_W'(1);
        ev_valid      = 1'b1;
        ev.kind       = EV_NAME_BYTE;
        ev.token_byte = data_byte;
      end
    end

    if (do_value) begin
      if (is_lf) begin
        state_next      = ST_LINE;
        ev_valid        = 1'b1;
        ev.kind         = EV_FIELD_END;
        ev.token_length = tlen_base;
        ev.name_count   = nlen_base;
      end else if (vlen_base < VALUE_CAP_L) begin
        value_len_next = vlen_inc;
        if (!ws) trimmed_len_next = vlen_inc;
        ev_valid      = 1'b1;
        ev.kind       = EV_VALUE_BYTE;
        ev.token_byte = data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_START;
      name_len    <= '0;
      value_len   <= '0;
      trimmed_len <= '0;
    end else if (advance) begin
      state       <= state_next;
      name_len    <= name_len_next;
      value_len   <= value_len_next;
      trimmed_len <= trimmed_len_next;
    end
  end

endmodule

// ----- src/request_header_tokenizer.sv -----
// ----------------------------------------------------------------------------
// request_header_tokenizer
// Each byte passes the input register, then the parse step into the result register.
// Throughput: one byte per cycle unless the token output stalls; the single parse step sets the rate.
// Bytes that raise no token leave nothing on the output.
// Reset (synchronous): parser returns to start with all counts zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "request_header_tokenizer_macros.svh"

module request_header_tokenizer (
  input  logic         clk,
  input  logic         rst,
  rht_byte_if.sink     bytes,
  rht_token_if.source  tokens
);
  import rht_pkg::*;

  stage_t stage;
  logic   out_free;
  logic   advance;
  logic   ev_valid;
  token_t ev;

  assign out_free = !tokens.valid || tokens.ready;
  assign advance  = stage.valid && out_free;

  rht_input_reg u_input_reg (
    .clk     (clk),
    .rst     (rst),
    .bytes   (bytes),
    .advance (advance),
    .stage   (stage)
  );

  rht_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .data_byte (stage.data),
    .ev_valid  (ev_valid),
    .ev        (ev)
  );

  // load a token beat when the parser consumes a byte that raises a token
  always_ff @(posedge clk) begin
    if (rst) begin
      tokens.valid <= 1'b0;
    end else if (out_free) begin
      tokens.valid <= advance && ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ev_valid) begin
      tokens.event_kind   <= ev.kind;
      tokens.token_byte   <= ev.token_byte;
      tokens.token_length <= ev.token_length;
      tokens.name_count   <= ev.name_count;
    end
  end

  `RHT_ASSERT_IMP(a_end_no_byte, clk, rst, tokens.valid && (tokens.event_kind == EV_METHOD_END || tokens.event_kind == EV_FIELD_END || tokens.event_kind == EV_HEADERS_END), tokens.token_byte == 8'd0)
  `RHT_ASSERT_IMP(a_byte_no_len, clk, rst, tokens.valid && (tokens.event_kind == EV_METHOD_BYTE || tokens.event_kind == EV_NAME_BYTE || tokens.event_kind == EV_VALUE_BYTE), tokens.token_length == '0 && tokens.name_count == '0)
  `RHT_ASSERT_NEXT(a_stage_hold, clk, rst, stage.valid && !advance, stage.valid && $stable(stage.data))
  `RHT_ASSERT_NEXT(a_stage_load, clk, rst, bytes.valid && bytes.ready, stage.valid)

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for request_header_tokenizer. A directed table walks the
// request line, header lines, blank line and the corner cases of the parser;
// random messages follow, mostly well formed with random content, mixed with
// noise, plus one message that runs the name count past its cap.
// Every byte beat is fed to a cycle-free predictor of the parser, and every
// token beat is compared field by field with the oldest predicted token.
// Sender gaps and receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import rht_pkg::*;

  typedef struct {
    logic [7:0]        data;
    bit                fixed;
    bit                fixed_has;
    event_kind_t       kind;
    logic [7:0]        tbyte;
    logic [LEN_W-1:0]  tlen;
    logic [NAME_W-1:0] tname;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 23;

  logic clk;
  logic rst;

  rht_byte_if  byte_ch ();
  rht_token_if token_ch ();

  request_header_tokenizer dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (byte_ch),
    .tokens (token_ch)
  );

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int mismatches    = 0;
  int bytes_sent    = 0;

  token_t expected_tokens [$];

  parse_state_t      prs_state   = ST_START;
  logic [NAME_W-1:0] name_bytes  = '0;
  logic [LEN_W-1:0]  stored_len  = '0;
  logic [LEN_W-1:0]  trimmed_len = '0;

  stim_row_t directed [DIRECTED_ROWS] = '{
    '{CHAR_SP,    1, 0, EV_METHOD_BYTE, 8'h00, 11'd0, 8'd0},
    '{8'h00,      1, 1, EV_METHOD_BYTE, 8'h00, 11'd0, 8'd0},
    '{8'hFF,      1, 1, EV_METHOD_BYTE, 8'hFF, 11'd0, 8'd0},
    '{CHAR_LF,    1, 1, EV_METHOD_END,  8'h00, 11'd2, 8'd0},
    '{CHAR_CR,    1, 0, EV_METHOD_BYTE, 8'h00, 11'd0, 8'd0},
    '{"N",        0, 0, EV_METHOD_BYTE, 8'h00, 11'd0, 8'd0},
    '{CHAR_LF,    1, 0, EV_METHOD_BYTE, 8'h00, 11'd0, 8'd0},
    '{"A",        0, 0, EV_METHOD_BYTE, 8'h00, 11'd0, 8'd0},
    '{CHAR_COLON, 1, 0, EV_METHOD_BYTE, 8'h00, 11'd0, 8'd0},
    '{CHAR_SP,    1, 0, EV_METHOD_BYTE, 8'h00, 11'd0, 8'd0},
    '{CHAR_LF,    1, 1, EV_FIELD_END,   8'h00, 11'd0, 8'd1},
    '{"B",        0, 0, EV_METHOD_BYTE, 8'h00, 11'd0, 8'd0},
    '{CHAR_COLON, 1, 0, EV_METHOD_BYTE, 8'h00, 11'd0, 8'd0},
    '{"v",        0, 0, EV_METHOD_BYTE, 8'h00, 11'd0, 8'd0},
    '{CHAR_SP,    0, 0, EV_METHOD_BYTE, 8'h00, 11'd0, 8'd0},
    '{CHAR_LF,    1, 1, EV_FIELD_END,   8'h00, 11'd1, 8'd1},
    '{CHAR_CR,    1, 0, EV_METHOD_BYTE, 8'h00, 11'd0, 8'd0},
    '{CHAR_LF,    1, 1, EV_HEADERS_END, 8'h00, 11'd0, 8'd0},
    '{"M",        0, 0, EV_METHOD_BYTE, 8'h00, 11'd0, 8'd0},
    '{CHAR_SP,    1, 1, EV_METHOD_END,  8'h00, 11'd1, 8'd0},
    '{"u",        0, 0, EV_METHOD_BYTE, 8'h00, 11'd0, 8'd0},
    '{CHAR_LF,    1, 0, EV_METHOD_BYTE, 8'h00, 11'd0, 8'd0},
    '{CHAR_LF,    1, 1, EV_HEADERS_END, 8'h00, 11'd0, 8'd0}
  };

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic bit is_space(input logic [7:0] b);
    return b inside {CHAR_SP, [CHAR_TAB:CHAR_CR]};
  endfunction

  function automatic token_t make_token(input event_kind_t k, input logic [7:0] b,
                                        input logic [LEN_W-1:0] len,
                                        input logic [NAME_W-1:0] nm);
    token_t t;
    t.kind         = k;
    t.token_byte   = b;
    t.token_length = len;
    t.name_count   = nm;
    return t;
  endfunction

  function automatic bit method_step(input logic [7:0] b, output token_t t);
    t = '0;
    if (is_space(b)) begin
      t = make_token(EV_METHOD_END, 8'h00, stored_len, '0);
      stored_len = '0;
      prs_state = (b == CHAR_LF) ? ST_LINE : ST_METHOD_GAP;
      return 1'b1;
    end
    if (stored_len < VALUE_CAP_L) begin
      stored_len++;
      t = make_token(EV_METHOD_BYTE, b, '0, '0);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit name_step(input logic [7:0] b, output token_t t);
    t = '0;
    if (b == CHAR_COLON) begin
      prs_state = ST_NAME_GAP;
      return 1'b0;
    end
    if (b == CHAR_LF) begin
      prs_state = ST_LINE;
      return 1'b0;
    end
    if (name_bytes < NAME_CAP_L) begin
      name_bytes++;
      t = make_token(EV_NAME_BYTE, b, '0, '0);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit value_step(input logic [7:0] b, output token_t t);
    t = '0;
    if (b == CHAR_LF) begin
      prs_state = ST_LINE;
      t = make_token(EV_FIELD_END, 8'h00, trimmed_len, name_bytes);
      return 1'b1;
    end
    if (stored_len < VALUE_CAP_L) begin
      stored_len++;
      if (!is_space(b)) trimmed_len = stored_len;
      t = make_token(EV_VALUE_BYTE, b, '0, '0);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit tokenize_byte(input logic [7:0] b, output token_t t);
    t = '0;
    case (prs_state)
      ST_START: begin
        if (is_space(b)) return 1'b0;
        name_bytes  = '0;
        stored_len  = '0;
        trimmed_len = '0;
        prs_state   = ST_METHOD;
        return method_step(b, t);
      end
      ST_METHOD: begin
        return method_step(b, t);
      end
      ST_METHOD_GAP: begin
        if (b == CHAR_LF) prs_state = ST_LINE;
        else if (!is_space(b)) prs_state = ST_URL;
        return 1'b0;
      end
      ST_URL: begin
        if (b == CHAR_LF) prs_state = ST_LINE;
        else if (is_space(b)) prs_state = ST_URL_GAP;
        return 1'b0;
      end
      ST_URL_GAP: begin
        if (b == CHAR_LF) prs_state = ST_LINE;
        else if (!is_space(b)) prs_state = ST_SKIP;
        return 1'b0;
      end
      ST_SKIP: begin
        if (b == CHAR_LF) prs_state = ST_LINE;
        return 1'b0;
      end
      ST_LINE: begin
        if (b == CHAR_CR) return 1'b0;
        if (b == CHAR_LF) begin
          prs_state = ST_START;
          t = make_token(EV_HEADERS_END, 8'h00, '0, '0);
          return 1'b1;
        end
        name_bytes  = '0;
        stored_len  = '0;
        trimmed_len = '0;
        prs_state   = ST_NAME;
        return name_step(b, t);
      end
      ST_NAME: begin
        return name_step(b, t);
      end
      ST_NAME_GAP: begin
        if (b != CHAR_LF && is_space(b)) return 1'b0;
        stored_len  = '0;
        trimmed_len = '0;
        prs_state   = ST_VALUE;
        return value_step(b, t);
      end
      ST_VALUE: begin
        return value_step(b, t);
      end
      default: begin
        prs_state = ST_START;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic logic [7:0] pick_text(input bit allow_space);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while (b == CHAR_LF || b == CHAR_COLON || (!allow_space && is_space(b)));
    return b;
  endfunction

  function automatic logic [7:0] pick_space();
    logic [7:0] spaces [6];
    spaces = '{CHAR_SP, CHAR_TAB, CHAR_LF, 8'h0B, 8'h0C, CHAR_CR};
    return spaces[$urandom_range(5)];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_byte(input logic [7:0] b, input bit fixed = 1'b0,
                           input bit fixed_has = 1'b0, input token_t fixed_tok = '0);
    token_t predicted;
    bit     has_tok;
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    has_tok = tokenize_byte(b, predicted);
    if (fixed) begin
      has_tok   = fixed_has;
      predicted = fixed_tok;
    end
    if (has_tok) expected_tokens.push_back(predicted);
    bytes_sent++;
    do @(posedge clk); while (!byte_ch.ready);
  endtask

  task automatic send_message();
    int shape;
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
    end
    repeat ($urandom_range(2)) send_byte(pick_space());
    repeat ($urandom_range(6, 1)) send_byte(pick_text(1'b0));
    if ($urandom_range(9) == 0) begin
      send_byte(CHAR_LF);
    end else begin
      send_byte(CHAR_SP);
      repeat ($urandom_range(6, 1)) send_byte(pick_text(1'b0));
      if ($urandom_range(3) != 0) begin
        send_byte(CHAR_SP);
        repeat ($urandom_range(6, 1)) send_byte(pick_text(1'b1));
      end
      if ($urandom_range(1)) send_byte(CHAR_CR);
      send_byte(CHAR_LF);
    end
    repeat ($urandom_range(4)) begin
      shape = $urandom_range(9);
      if ($urandom_range(4) == 0) send_byte(CHAR_CR);
      repeat ($urandom_range(8, 1)) send_byte(pick_text(1'b1));
      if (shape != 0) begin
        send_byte(CHAR_COLON);
        repeat ($urandom_range(2)) send_byte($urandom_range(1) ? CHAR_SP : CHAR_TAB);
        if (shape != 1) repeat ($urandom_range(10, 1)) send_byte(pick_text(1'b1));
        repeat ($urandom_range(2)) send_byte(CHAR_SP);
      end
      if ($urandom_range(3) != 0) send_byte(CHAR_CR);
      send_byte(CHAR_LF);
    end
    if ($urandom_range(1)) send_byte(CHAR_CR);
    send_byte(CHAR_LF);
  endtask

  task automatic send_oversize();
    send_byte("X");
    send_byte(CHAR_SP);
    send_byte("u");
    send_byte(CHAR_LF);
    repeat (NAME_CAP + 5) send_byte(pick_text(1'b1));
    send_byte(CHAR_COLON);
    repeat (4) send_byte(pick_text(1'b0));
    send_byte(CHAR_LF);
    send_byte(CHAR_LF);
  endtask

  initial begin
    token_t seen;
    token_t want;
    token_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && token_ch.valid && token_ch.ready) begin
        seen.kind         = token_ch.event_kind;
        seen.token_byte   = token_ch.token_byte;
        seen.token_length = token_ch.token_length;
        seen.name_count   = token_ch.name_count;
        if (expected_tokens.size() == 0) begin
          report_mismatch($sformatf("unexpected token kind %0d byte %02h len %0d name %0d",
                                    seen.kind, seen.token_byte, seen.token_length,
                                    seen.name_count));
        end else begin
          want = expected_tokens.pop_front();
          if (seen !== want)
            report_mismatch($sformatf(
              "token got kind %0d byte %02h len %0d name %0d, want %0d %02h %0d %0d",
              seen.kind, seen.token_byte, seen.token_length, seen.name_count,
              want.kind, want.token_byte, want.token_length, want.name_count));
        end
      end
      token_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    int send_pcts  [4];
    int stall_pcts [4];
    int target;
    send_pcts  = '{0, 67, 0, 29};
    stall_pcts = '{0, 0, 67, 29};
    rst = 1'b1;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      send_byte(directed[i].data, directed[i].fixed, directed[i].fixed_has,
                make_token(directed[i].kind, directed[i].tbyte, directed[i].tlen,
                           directed[i].tname));
    end
    send_oversize();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pcts[p];
      stall_pct     = stall_pcts[p];
      target        = bytes_sent + 180;
      while (bytes_sent < target) send_message();
    end
    byte_ch.valid <= 1'b0;

    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("request_header_tokenizer: match");
    end else begin
      $display("request_header_tokenizer: mismatch");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("request_header_tokenizer: mismatch");
    $finish;
  end

endmodule
